>>> sv/ipr_pkg.sv
// ----------------------------------------------------------------------------
// ipr_pkg
// Types, codes and sizes shared by the IPv4 range table search core.
// ----------------------------------------------------------------------------
package ipr_pkg;

  localparam int unsigned TABLE_DEPTH = 8192;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EIDX_W      = 13;
  localparam int unsigned CMP_W       = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;

  localparam logic [1:0] ISP_MAX = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              command;
    logic [31:0]       lookup_ip;
    logic [31:0]       new_first;
    logic [31:0]       new_last;
    logic [1:0]        new_isp;
    logic [EIDX_W-1:0] entry_index;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  hit_isp;
    logic [31:0] hit_first;
    logic [31:0] hit_last;
    status_e     status;
  } out_t;

  typedef struct packed {
    logic [1:0]  isp;
    logic [31:0] last;
    logic [31:0] first;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic valid;
    out_t data;
  } ctrl_res_t;

  function automatic out_t entry_res(entry_t e);
    out_t r;
    r.hit       = 1'b1;
    r.hit_isp   = e.isp;
    r.hit_first = e.first;
    r.hit_last  = e.last;
    r.status    = ST_OK;
    return r;
  endfunction

endpackage

>>> sv/ipr_ram.sv
// ----------------------------------------------------------------------------
// ipr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ipr_ram #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 1,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ipr_ctrl.sv
// ----------------------------------------------------------------------------
// ipr_ctrl
// Command sequencer: entry count, append writes, indexed reads and the
// one-probe-per-cycle binary search over the range memory.
// ----------------------------------------------------------------------------
module ipr_ctrl import ipr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output ctrl_res_t        res_o,
  input  logic             res_take_i,
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output entry_t           mem_wdata_o,
  output logic             mem_re_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  entry_t           mem_rdata_i
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_READ   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;
  logic [CNT_W-1:0] mid_q, mid_d;
  logic [31:0]      ip_q, ip_d;
  out_t             res_q, res_d;

  logic [CNT_W-1:0] cnt_m1, first_mid;
  logic [CNT_W-1:0] nlo, nhi, nmid;
  logic [CNT_W:0]   msum;
  logic [CMP_W-1:0] idx_ext, cnt_ext;
  logic             below, above;

  assign cnt_m1    = count_q - CNT_W'(1);
  assign first_mid = cnt_m1 >> 1;
  assign idx_ext   = CMP_W'(in_data_i.entry_index);
  assign cnt_ext   = CMP_W'(count_q);

  assign below = ip_q < mem_rdata_i.first;
  assign above = ip_q > mem_rdata_i.last;

  always_comb begin
    nlo = lo_q;
    nhi = hi_q;
    if (below) begin
      nhi = mid_q;
    end else begin
      nlo = mid_q + CNT_W'(1);
    end
  end

  assign msum = {1'b0, nlo} + {1'b0, nhi} - (CNT_W + 1)'(1);
  assign nmid = msum[CNT_W:1];

  assign mem_wdata_o.isp   = in_data_i.new_isp;
  assign mem_wdata_o.first = in_data_i.new_first;
  assign mem_wdata_o.last  = in_data_i.new_last;
  assign mem_waddr_o       = count_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    ip_d        = ip_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ip_d  = in_data_i.lookup_ip;
          res_d = '0;
          unique case (in_data_i.command)
            CMD_CLEAR: begin
              count_d = '0;
              state_d = S_DONE;
            end
            CMD_APPEND: begin
              if (count_q >= CNT_W'(TABLE_DEPTH)) begin
                res_d.status = ST_FULL;
              end else if (in_data_i.new_isp <= ISP_MAX) begin
                mem_we_o = 1'b1;
                count_d  = count_q + CNT_W'(1);
              end
              state_d = S_DONE;
            end
            CMD_LOOKUP: begin
              lo_d = '0;
              hi_d = count_q;
              if (count_q == '0) begin
                state_d = S_DONE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = first_mid[IDX_W-1:0];
                mid_d       = first_mid;
                state_d     = S_SEARCH;
              end
            end
            CMD_READ: begin
              if (idx_ext < cnt_ext) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = idx_ext[IDX_W-1:0];
                state_d     = S_READ;
              end else begin
                res_d.status = ST_RANGE;
                state_d      = S_DONE;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (!below && !above) begin
          res_d   = entry_res(mem_rdata_i);
          state_d = S_DONE;
        end else begin
          lo_d = nlo;
          hi_d = nhi;
          if (nlo < nhi) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = nmid[IDX_W-1:0];
            mid_d       = nmid;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_READ: begin
        res_d   = entry_res(mem_rdata_i);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = state_q != S_IDLE;
  assign res_o.valid = state_q == S_DONE;
  assign res_o.data  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    ip_q  <= ip_d;
    res_q <= res_d;
  end

endmodule

>>> sv/ip_range_table_search_core.sv
// ----------------------------------------------------------------------------
// ip_range_table_search_core
// IPv4 range table: clear, append, binary-search lookup and indexed read.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/in_stall_o  | in_data_i  (in_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (out_t)
//
//  One transaction in flight. Clear, append and out-of-range read go from idle
//  straight to done, read passes through the read state, and lookup searches
//  with probes <= ceil(log2(count+1)); one memory read port, one probe/cycle.
//  Output register lets the next transaction start while a result is stalled.
//  Reset empties the table; entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module ip_range_table_search_core import ipr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  ctrl_res_t        res;
  logic             res_take;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  entry_t           mem_wdata, mem_rdata;
  logic             out_valid_q, out_valid_d;
  out_t             out_q;

  ipr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .res_o       (res),
    .res_take_i  (res_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ipr_ram #(
    .Depth (TABLE_DEPTH),
    .Width (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_take = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid && res_take) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_take) begin
      out_q <= res.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/ipr_checker.sv
// ----------------------------------------------------------------------------
// ipr_checker
// Port-level checks for the range table core, bound to the top level.
// ----------------------------------------------------------------------------
module ipr_checker import ipr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      out_data_o.hit_isp == '0 && out_data_o.hit_first == '0 &&
      out_data_o.hit_last == '0)
    else $error("miss carries entry fields");

  a_err_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_FULL || out_data_o.status == ST_RANGE)
      |-> !out_data_o.hit)
    else $error("error status with hit");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted while busy");

  a_hit_isp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.hit |-> out_data_o.hit_isp <= ISP_MAX &&
      out_data_o.status == ST_OK)
    else $error("hit with bad carrier or status");

endmodule

bind ip_range_table_search_core ipr_checker u_ipr_checker (.*);

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv4 range table search core.
// Drives clear, append, lookup and read transactions with random idle gaps
// and output stalls. A bench-side copy of the range table predicts every
// answer, and each answer is compared field by field in arrival order.
// Covers the empty table, the range edges, a long output hold-off and
// random sorted tables mixed with noise.
// ----------------------------------------------------------------------------
module tb;
  import ipr_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned IDLE_MAX     = 14;
  localparam int unsigned HOLDOFF      = 300;
  localparam int unsigned SETTLE       = 32;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned IDX_MAX      = (1 << EIDX_W) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_t  in_data = '0;
  logic in_stall_o;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_t out_data_o;

  logic [31:0] range_lo_mem  [TABLE_DEPTH];
  logic [31:0] range_hi_mem  [TABLE_DEPTH];
  logic [1:0]  range_isp_mem [TABLE_DEPTH];
  int unsigned range_count = 0;

  out_t        expected_answers [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  bit          sender_idle = 1'b0;
  bit          receiver_idle = 1'b0;
  int unsigned holdoff_cycles = 0;

  ip_range_table_search_core i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic out_t apply_table_command(in_t op);
    out_t r;
    int   lo_i;
    int   hi_i;
    int   mid;
    int   sel;
    r   = '0;
    sel = -1;
    case (op.command)
      CMD_CLEAR: begin
        range_count = 0;
      end
      CMD_APPEND: begin
        if (range_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else if (op.new_isp <= ISP_MAX) begin
          range_lo_mem[range_count]  = op.new_first;
          range_hi_mem[range_count]  = op.new_last;
          range_isp_mem[range_count] = op.new_isp;
          range_count++;
        end
      end
      CMD_LOOKUP: begin
        lo_i = 0;
        hi_i = int'(range_count) - 1;
        while (lo_i <= hi_i) begin
          mid = (lo_i + hi_i) / 2;
          if (op.lookup_ip < range_lo_mem[mid]) begin
            hi_i = mid - 1;
          end else if (op.lookup_ip > range_hi_mem[mid]) begin
            lo_i = mid + 1;
          end else begin
            sel = mid;
            break;
          end
        end
      end
      default: begin
        if (op.entry_index < range_count) sel = op.entry_index;
        else r.status = ST_RANGE;
      end
    endcase
    if (sel >= 0) begin
      r.hit       = 1'b1;
      r.hit_isp   = range_isp_mem[sel];
      r.hit_first = range_lo_mem[sel];
      r.hit_last  = range_hi_mem[sel];
      r.status    = ST_OK;
    end
    return r;
  endfunction

  function automatic in_t make_item(cmd_e cmd);
    in_t op;
    op.command     = cmd;
    op.lookup_ip   = $urandom;
    op.new_first   = $urandom;
    op.new_last    = $urandom;
    op.new_isp     = 2'($urandom_range(0, ISP_MAX));
    op.entry_index = EIDX_W'($urandom_range(0, IDX_MAX));
    return op;
  endfunction

  // called at a rising edge; returns at the edge where the transaction is taken
  task automatic send_item(input in_t op);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    expected_answers.push_back(apply_table_command(op));
    items_sent++;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
  endtask

  task automatic send_clear();
    send_item(make_item(CMD_CLEAR));
  endtask

  task automatic send_append(input logic [31:0] first, input logic [31:0] last,
                             input logic [1:0] isp);
    in_t op;
    op           = make_item(CMD_APPEND);
    op.new_first = first;
    op.new_last  = last;
    op.new_isp   = isp;
    send_item(op);
  endtask

  task automatic send_lookup(input logic [31:0] ip);
    in_t op;
    op           = make_item(CMD_LOOKUP);
    op.lookup_ip = ip;
    send_item(op);
  endtask

  task automatic send_read(input int unsigned idx);
    in_t op;
    op             = make_item(CMD_READ);
    op.entry_index = EIDX_W'(idx);
    send_item(op);
  endtask

  function automatic logic [31:0] address_in_entry(int unsigned sel);
    if (range_lo_mem[sel] > range_hi_mem[sel]) return range_lo_mem[sel];
    case ($urandom_range(0, 3))
      0:       return range_lo_mem[sel];
      1:       return range_hi_mem[sel];
      default: return range_lo_mem[sel] +
                      $urandom_range(0, range_hi_mem[sel] - range_lo_mem[sel]);
    endcase
  endfunction

  // n ascending, non-overlapping ranges spread over the whole address space
  task automatic append_sorted(input int unsigned n, input bit with_noise);
    logic [63:0] step;
    logic [63:0] base;
    logic [31:0] first;
    logic [31:0] last;
    step = 64'h1_0000_0000 / n;
    for (int unsigned i = 0; i < n; i++) begin
      base  = step * i;
      first = 32'(base + $urandom_range(0, 32'(step / 2) - 1));
      last  = first + $urandom_range(0, 32'(step / 2) - 1);
      if (i == 0 && $urandom_range(0, 3) == 0) first = 32'h0;
      if (i == n - 1 && $urandom_range(0, 3) == 0) last = 32'hFFFF_FFFF;
      send_append(first, last, 2'($urandom_range(0, ISP_MAX)));
      if (with_noise && $urandom_range(0, 15) == 0) begin
        send_append($urandom, $urandom, 2'd3);
      end
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_result(input out_t got);
    out_t exp;
    if (expected_answers.size() == 0) begin
      $error("result transaction with no expectation pending");
      mismatch_count++;
    end else begin
      exp = expected_answers.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, actual %0d", exp.hit, got.hit);
        mismatch_count++;
      end
      if (got.hit_isp !== exp.hit_isp) begin
        $error("hit_isp: expected %0d, actual %0d", exp.hit_isp, got.hit_isp);
        mismatch_count++;
      end
      if (got.hit_first !== exp.hit_first) begin
        $error("hit_first: expected %h, actual %h", exp.hit_first, got.hit_first);
        mismatch_count++;
      end
      if (got.hit_last !== exp.hit_last) begin
        $error("hit_last: expected %h, actual %h", exp.hit_last, got.hit_last);
        mismatch_count++;
      end
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        mismatch_count++;
      end
    end
  endtask

  // result side: stall for a drawn number of cycles, then take one transaction
  initial begin : result_monitor
    int unsigned gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holdoff_cycles > 0) begin
        gap            = holdoff_cycles;
        holdoff_cycles = 0;
      end else begin
        gap = receiver_idle ? $urandom_range(0, IDLE_MAX) : 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid_o) @(posedge clk);
      check_result(out_data_o);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("ip_range_table_search_core verification failed");
    $finish;
  end

  task automatic test_empty_table();
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    send_lookup($urandom);
    send_lookup(32'h0);
    send_read(0);
    send_read(IDX_MAX);
    send_clear();
    drain_results();
  endtask

  task automatic test_edges();
    send_append(32'h0000_0000, 32'h0000_0000, 2'd0);
    send_append(32'h0000_000A, 32'h0000_0014, 2'd1);
    send_append(32'h8000_0000, 32'h8000_00FF, 2'd2);
    send_append(32'hFFFF_FF00, 32'hFFFF_FFFF, 2'd2);
    send_append(32'h1234_5678, 32'h1234_5678, 2'd3);  // unknown carrier, dropped
    send_lookup(32'h0000_0000);
    send_lookup(32'h0000_000A);
    send_lookup(32'h0000_0014);
    send_lookup(32'h0000_000F);
    send_lookup(32'h0000_0015);
    send_lookup(32'h0000_0005);
    send_lookup(32'h8000_0080);
    send_lookup(32'hFFFF_FFFF);
    send_read(0);
    send_read(3);
    send_read(4);
    send_read(IDX_MAX);
    send_append(32'h0000_0100, 32'h0000_0050, 2'd1);  // inverted range
    send_lookup(32'h0000_0080);
    send_read(4);
    send_clear();
    send_read(0);
    send_lookup(32'h8000_0080);
    drain_results();
  endtask

  task automatic test_output_holdoff();
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    send_clear();
    append_sorted(8, 1'b0);
    holdoff_cycles = HOLDOFF;
    for (int i = 0; i < 24; i++) begin
      send_lookup(address_in_entry($urandom_range(0, range_count - 1)));
    end
    drain_results();
  endtask

  task automatic send_random_query();
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(0, 99);
    sel  = (range_count > 0) ? $urandom_range(0, range_count - 1) : 0;
    if (pick < 35 && range_count > 0) begin
      send_lookup(address_in_entry(sel));
    end else if (pick < 50 && range_count > 0) begin
      if ($urandom_range(0, 1)) send_lookup(range_lo_mem[sel] - 32'd1);
      else send_lookup(range_hi_mem[sel] + 32'd1);
    end else if (pick < 60) begin
      send_lookup($urandom);
    end else if (pick < 78 && range_count > 0) begin
      send_read(sel);
    end else if (pick < 86) begin
      send_read($urandom_range(0, IDX_MAX));
    end else if (pick < 97) begin
      send_append($urandom, $urandom, 2'($urandom_range(0, 3)));
    end else begin
      send_clear();
    end
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) != 0) send_clear();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 200) : $urandom_range(1, 24);
      append_sorted(n, 1'b1);
      repeat ($urandom_range(10, 40)) send_random_query();
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_edges();
    test_output_holdoff();
    test_random_traffic();
    if (mismatch_count == 0) begin
      $display("ip_range_table_search_core verification clean");
    end else begin
      $display("ip_range_table_search_core verification failed");
    end
    $finish;
  end

endmodule
